// ===== rtl/ptfm_pkg.sv =====
// shared types, constants and lookup functions of the psg to fm register translator
package ptfm_pkg;

   localparam int KEY_W       = 24;
   localparam int N_W         = 14;
   localparam int NUM_SLOTS   = 24;
   localparam int SLOT_IDX_W  = 5;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = 2;
   localparam int FIFO_CNT_W  = 3;
   localparam int LOG_STEPS   = 16;
   localparam int ENV_WAVE_MAX = 200;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_PAN   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      CSR_KEY_OFFSET  = 1'b0,
      CSR_STEREO_MODE = 1'b1
   } csr_index_type;

   localparam logic [KEY_W-1:0] KEY_OFFSET_RESET = 24'd9932800;

   // fm register addresses
   localparam logic [7:0] FM_KEY_ONOFF = 8'h08;
   localparam logic [7:0] FM_NOISE     = 8'h0F;
   localparam logic [7:0] FM_PAN_BASE  = 8'h24;
   localparam logic [7:0] FM_NOISE_PAN = 8'h27;
   localparam logic [7:0] FM_KC_BASE   = 8'h2C;
   localparam logic [7:0] FM_KF_BASE   = 8'h34;
   localparam logic [7:0] FM_TL_BASE   = 8'h74;
   localparam logic [7:0] FM_NOISE_TL  = 8'h7F;
   localparam logic [7:0] PAN_FEEDBACK = 8'h3C;

   // slot kinds of the front sequencer
   typedef enum logic [2:0] {
      SK_TLPRE,
      SK_FREQ,
      SK_TL,
      SK_KEY,
      SK_RETRIG,
      SK_TLPOST,
      SK_PAN,
      SK_NOISE
   } slot_kind_type;

   typedef struct packed {
      slot_kind_type kind;
      logic [1:0]    sel;
   } slot_type;

   // envelope segment kinds
   typedef enum logic [1:0] {
      SEG_UP   = 2'd0,
      SEG_DOWN = 2'd1,
      SEG_LOW  = 2'd2,
      SEG_HIGH = 2'd3
   } seg_kind_type;

   // back stage states
   typedef enum logic [2:0] {B_IDLE, B_LOG, B_KEY, B_KC, B_KF} back_state_type;

   typedef struct packed {
      logic             is_key;
      logic             last;
      logic [7:0]       addr;
      logic [N_W-1:0]   value;
   } op_type;

   // slot positions: five per voice, then post levels, pans, noise writes
   localparam logic [NUM_SLOTS-1:0] EMIT_MASK = 24'hFF_BDEF;

   function automatic slot_type decode_slot(input logic [SLOT_IDX_W-1:0] idx);
      slot_type s;
      logic [SLOT_IDX_W-1:0] sub;
      s.kind = SK_NOISE;
      s.sel  = 2'd0;
      sub    = idx;
      if (idx < 5'd15) begin
         if (idx < 5'd5) begin
            s.sel = 2'd0;
            sub   = idx;
         end else if (idx < 5'd10) begin
            s.sel = 2'd1;
            sub   = idx - 5'd5;
         end else begin
            s.sel = 2'd2;
            sub   = idx - 5'd10;
         end
         case (sub)
            5'd0:    s.kind = SK_TLPRE;
            5'd1:    s.kind = SK_FREQ;
            5'd2:    s.kind = SK_TL;
            5'd3:    s.kind = SK_KEY;
            default: s.kind = SK_RETRIG;
         endcase
      end else if (idx < 5'd18) begin
         s.kind = SK_TLPOST;
         s.sel  = 2'(idx - 5'd15);
      end else if (idx < 5'd21) begin
         s.kind = SK_PAN;
         s.sel  = 2'(idx - 5'd18);
      end else begin
         s.kind = SK_NOISE;
         s.sel  = 2'(idx - 5'd21);
      end
      return s;
   endfunction

   function automatic logic [6:0] tone_tl(input logic [3:0] vol);
      logic [6:0] r;
      case (vol)
         4'd0:    r = 7'd127;
         4'd1:    r = 7'd62;
         4'd2:    r = 7'd56;
         4'd3:    r = 7'd52;
         4'd4:    r = 7'd46;
         4'd5:    r = 7'd42;
         4'd6:    r = 7'd36;
         4'd7:    r = 7'd32;
         4'd8:    r = 7'd28;
         4'd9:    r = 7'd24;
         4'd10:   r = 7'd20;
         4'd11:   r = 7'd16;
         4'd12:   r = 7'd12;
         4'd13:   r = 7'd8;
         4'd14:   r = 7'd4;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] noise_tl(input logic [3:0] vol);
      logic [6:0] r;
      case (vol)
         4'd0:    r = 7'd127;
         4'd1:    r = 7'd126;
         4'd2:    r = 7'd125;
         4'd3:    r = 7'd124;
         4'd4:    r = 7'd123;
         4'd5:    r = 7'd122;
         4'd6:    r = 7'd121;
         4'd7:    r = 7'd120;
         4'd8:    r = 7'd116;
         4'd9:    r = 7'd112;
         4'd10:   r = 7'd105;
         4'd11:   r = 7'd96;
         4'd12:   r = 7'd82;
         4'd13:   r = 7'd64;
         4'd14:   r = 7'd37;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] note_code(input logic [3:0] note);
      logic [3:0] r;
      case (note)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd1;
         4'd2:    r = 4'd2;
         4'd3:    r = 4'd4;
         4'd4:    r = 4'd5;
         4'd5:    r = 4'd6;
         4'd6:    r = 4'd8;
         4'd7:    r = 4'd9;
         4'd8:    r = 4'd10;
         4'd9:    r = 4'd12;
         4'd10:   r = 4'd13;
         default: r = 4'd14;
      endcase
      return r;
   endfunction

   function automatic seg_kind_type seg_kind(input logic [3:0] shape, input logic seg);
      seg_kind_type k;
      if (!shape[3]) begin
         k = seg ? SEG_LOW : (shape[2] ? SEG_UP : SEG_DOWN);
      end else begin
         case ({shape[2:0], seg})
            4'b000_0: k = SEG_DOWN;
            4'b000_1: k = SEG_DOWN;
            4'b001_0: k = SEG_DOWN;
            4'b001_1: k = SEG_LOW;
            4'b010_0: k = SEG_DOWN;
            4'b010_1: k = SEG_UP;
            4'b011_0: k = SEG_DOWN;
            4'b011_1: k = SEG_HIGH;
            4'b100_0: k = SEG_UP;
            4'b100_1: k = SEG_UP;
            4'b101_0: k = SEG_UP;
            4'b101_1: k = SEG_HIGH;
            4'b110_0: k = SEG_UP;
            4'b110_1: k = SEG_DOWN;
            4'b111_0: k = SEG_UP;
            default:  k = SEG_LOW;
         endcase
      end
      return k;
   endfunction

   function automatic logic [4:0] restart_level(input logic [3:0] shape, input logic seg);
      seg_kind_type k;
      k = seg_kind(shape, seg);
      return (k == SEG_DOWN || k == SEG_HIGH) ? 5'd31 : 5'd0;
   endfunction

   function automatic logic [7:0] voice_pan(input logic [1:0] mode, input logic [1:0] ch);
      logic [7:0] r;
      case ({mode, ch})
         4'b00_00: r = 8'h40;
         4'b00_01: r = 8'hC0;
         4'b00_10: r = 8'h80;
         4'b01_00: r = 8'h40;
         4'b01_01: r = 8'h80;
         4'b01_10: r = 8'hC0;
         4'b10_00: r = 8'hC0;
         4'b10_01: r = 8'h40;
         4'b10_10: r = 8'h80;
         default:  r = 8'hC0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ptfm_req_if.sv =====
// request and response channel interfaces
interface ptfm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] reg_addr;
   logic [7:0] reg_data;
   modport source (output valid, action, reg_addr, reg_data, input ready);
   modport sink (input valid, action, reg_addr, reg_data, output ready);
endinterface

interface ptfm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] fm_addr;
   logic [7:0] fm_data;
   logic       last;
   modport source (output valid, fm_addr, fm_data, last, input ready);
   modport sink (input valid, fm_addr, fm_data, last, output ready);
endinterface

// ===== rtl/ptfm_front.sv =====
// front sequencer: psg shadow, envelope model, and fm write/key ops into the queue
module ptfm_front (
   input  logic                 clock,
   input  logic                 reset,
   ptfm_req_if.sink             req_bus,
   input  logic [1:0]           stereo_mode,
   input  logic                 q_full,
   output logic                 q_push,
   output ptfm_pkg::op_type     q_op
);

   logic [7:0]  shadow_ff [16];
   logic [7:0]  shadow_in [16];
   logic [15:0] env_counter_ff, env_counter_in;
   logic [15:0] env_period_ff, env_period_in;
   logic [3:0]  env_shape_ff, env_shape_in;
   logic        env_seg_ff, env_seg_in;
   logic [4:0]  env_level_ff, env_level_in;
   logic [ptfm_pkg::NUM_SLOTS-1:0] mask_ff, mask_in;

   logic                         accept;
   logic                         step;
   logic [ptfm_pkg::SLOT_IDX_W-1:0] idx;
   logic [ptfm_pkg::NUM_SLOTS-1:0]  rest;
   ptfm_pkg::slot_type           slot;
   logic                         env_fast;
   logic                         env_wave [3];
   logic [ptfm_pkg::N_W-1:0]     freq_n [3];
   logic [7:0]                   tl_val [3];
   logic [3:0]                   noise_vol;
   logic                         noise_left, noise_right;
   logic [7:0]                   noise_pan;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (mask_ff == '0);
   assign step          = (mask_ff != '0) && !q_full;
   assign env_fast      = (env_period_ff < 16'(ptfm_pkg::ENV_WAVE_MAX));

   // lowest pending slot
   always_comb begin
      idx = '0;
      for (int i = ptfm_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) idx = ptfm_pkg::SLOT_IDX_W'(i);
      end
   end

   assign rest = mask_ff & (mask_ff - ptfm_pkg::NUM_SLOTS'(1));
   assign slot = ptfm_pkg::decode_slot(idx);

   // per-voice pitch period and level
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [7:0] v;
         logic [1:0] steps;
         v = shadow_ff[8 + c];
         env_wave[c] = v[4] && env_fast;
         unique case (env_shape_ff)
            4'd8, 4'd9, 4'd11, 4'd12, 4'd13, 4'd15: steps = 2'd1;
            4'd10, 4'd14:                            steps = 2'd2;
            default:                                 steps = 2'd0;
         endcase
         if (env_wave[c] && steps == 2'd1) begin
            freq_n[c] = {1'b0, env_period_ff[7:0], 5'd0};
         end else if (env_wave[c] && steps == 2'd2) begin
            freq_n[c] = {env_period_ff[7:0], 6'd0};
         end else begin
            freq_n[c] = {2'd0, shadow_ff[2*c + 1][3:0], shadow_ff[2*c]};
         end
         if (!shadow_ff[7][c] || env_wave[c]) begin
            if (v[4]) begin
               tl_val[c] = {1'b0, ptfm_pkg::tone_tl(env_wave[c] ? 4'd15 : env_level_ff[4:1])};
            end else begin
               tl_val[c] = {1'b0, ptfm_pkg::tone_tl(v[3:0])};
            end
         end else begin
            tl_val[c] = 8'h7F;
         end
      end
   end

   // noise mix of enabled voices
   always_comb begin
      noise_vol   = 4'd0;
      noise_left  = 1'b0;
      noise_right = 1'b0;
      for (int c = 0; c < 3; c++) begin
         logic [7:0] p;
         p = ptfm_pkg::voice_pan(stereo_mode, 2'(c));
         if (!shadow_ff[7][3 + c]) begin
            if (shadow_ff[8 + c][3:0] > noise_vol) noise_vol = shadow_ff[8 + c][3:0];
            if (p[6]) noise_left = 1'b1;
            if (p[7]) noise_right = 1'b1;
         end
      end
      if (noise_left && !noise_right)      noise_pan = 8'h40;
      else if (noise_right && !noise_left) noise_pan = 8'h80;
      else                                 noise_pan = 8'hC0;
   end

   // op for the current slot
   always_comb begin
      q_op        = '0;
      q_op.last   = ((rest & ptfm_pkg::EMIT_MASK) == '0);
      q_push      = step && slot.kind != ptfm_pkg::SK_RETRIG;
      unique case (slot.kind)
         ptfm_pkg::SK_TLPRE, ptfm_pkg::SK_TL, ptfm_pkg::SK_TLPOST: begin
            q_op.addr  = ptfm_pkg::FM_TL_BASE + 8'(slot.sel);
            q_op.value = ptfm_pkg::N_W'(tl_val[slot.sel]);
         end
         ptfm_pkg::SK_FREQ: begin
            q_op.is_key = 1'b1;
            q_op.addr   = 8'(slot.sel);
            q_op.value  = freq_n[slot.sel];
         end
         ptfm_pkg::SK_KEY: begin
            q_op.addr = ptfm_pkg::FM_KEY_ONOFF;
            if (!shadow_ff[7][slot.sel]) begin
               q_op.value = ptfm_pkg::N_W'(8'h78 | (8'(slot.sel) + 8'd4));
            end else begin
               q_op.value = ptfm_pkg::N_W'(8'(slot.sel) + 8'd4);
            end
         end
         ptfm_pkg::SK_RETRIG: begin
            q_op.addr = 8'd0;
         end
         ptfm_pkg::SK_PAN: begin
            q_op.addr  = ptfm_pkg::FM_PAN_BASE + 8'(slot.sel);
            q_op.value = ptfm_pkg::N_W'(ptfm_pkg::voice_pan(stereo_mode, slot.sel)
                                        | ptfm_pkg::PAN_FEEDBACK);
         end
         ptfm_pkg::SK_NOISE: begin
            if (slot.sel == 2'd0) begin
               q_op.addr  = ptfm_pkg::FM_NOISE;
               q_op.value = ptfm_pkg::N_W'(8'h80 | (8'h1F - {3'd0, shadow_ff[6][4:0]}));
            end else if (slot.sel == 2'd1) begin
               q_op.addr  = ptfm_pkg::FM_NOISE_PAN;
               q_op.value = ptfm_pkg::N_W'(noise_pan | ptfm_pkg::PAN_FEEDBACK);
            end else begin
               q_op.addr  = ptfm_pkg::FM_NOISE_TL;
               q_op.value = ptfm_pkg::N_W'(ptfm_pkg::noise_tl(noise_vol));
            end
         end
         default: q_op.addr = 8'd0;
      endcase
   end

   // state updates: slot side effects, or a newly accepted request
   always_comb begin
      logic [7:0]  a;
      logic [7:0]  d;
      logic [16:0] cnt_p1;
      logic        nseg;
      ptfm_pkg::seg_kind_type k;
      logic [15:0] per;
      a = req_bus.reg_addr;
      d = req_bus.reg_data;
      cnt_p1 = 17'(env_counter_ff) + 17'd1;
      nseg = ~env_seg_ff;
      k = ptfm_pkg::seg_kind(env_shape_ff, env_seg_ff);
      per = 16'd0;
      shadow_in      = shadow_ff;
      env_counter_in = env_counter_ff;
      env_period_in  = env_period_ff;
      env_shape_in   = env_shape_ff;
      env_seg_in     = env_seg_ff;
      env_level_in   = env_level_ff;
      mask_in        = mask_ff;
      if (step) begin
         mask_in = rest;
         if (slot.kind == ptfm_pkg::SK_RETRIG && shadow_ff[8 + slot.sel][4] &&
             env_shape_ff[0] == 1'b0 && env_shape_ff[3] == 1'b1) begin
            mask_in = rest;
         end else if (slot.kind == ptfm_pkg::SK_RETRIG && shadow_ff[8 + slot.sel][4]) begin
            env_counter_in = 16'd0;
            env_seg_in     = 1'b0;
            env_level_in   = ptfm_pkg::restart_level(env_shape_ff, 1'b0);
         end
      end else if (accept) begin
         unique case (req_bus.action)
            ptfm_pkg::ACT_WRITE: begin
               if (a < 8'd16) begin
                  shadow_in[a[3:0]] = d;
                  if (a <= 8'd5) begin
                     for (int c = 0; c < 3; c++) begin
                        if (a[2:1] == 2'(c)) begin
                           mask_in[5*c + 1] = 1'b1;
                           mask_in[5*c + 2] = 1'b1;
                           mask_in[5*c + 4] = 1'b1;
                        end
                     end
                  end else if (a == 8'd6) begin
                     mask_in[23:21] = 3'b111;
                  end else if (a == 8'd7) begin
                     for (int c = 0; c < 3; c++) begin
                        if (!d[c] && shadow_ff[7][c]) begin
                           mask_in[5*c + 1] = 1'b1;
                           mask_in[5*c + 2] = 1'b1;
                           mask_in[5*c + 3] = 1'b1;
                           mask_in[5*c + 4] = 1'b1;
                        end else if (d[c] && !shadow_ff[7][c]) begin
                           mask_in[5*c + 3] = 1'b1;
                        end
                     end
                     mask_in[17:15] = 3'b111;
                     mask_in[23:21] = 3'b111;
                  end else if (a <= 8'd10) begin
                     for (int c = 0; c < 3; c++) begin
                        if (a[1:0] == 2'(c)) begin
                           mask_in[5*c]     = 1'b1;
                           mask_in[5*c + 1] = 1'b1;
                        end
                     end
                     mask_in[23:21] = 3'b111;
                  end else if (a <= 8'd12) begin
                     per = {shadow_in[12], shadow_in[11]};
                     env_period_in = (per == 16'd0) ? 16'd1 : per;
                     mask_in[1]  = 1'b1;
                     mask_in[6]  = 1'b1;
                     mask_in[11] = 1'b1;
                  end else if (a == 8'd13) begin
                     env_shape_in   = d[3:0];
                     env_counter_in = 16'd0;
                     env_seg_in     = 1'b0;
                     env_level_in   = ptfm_pkg::restart_level(d[3:0], 1'b0);
                     mask_in[1]  = 1'b1;
                     mask_in[6]  = 1'b1;
                     mask_in[11] = 1'b1;
                  end
               end
            end
            ptfm_pkg::ACT_TICK: begin
               if (cnt_p1 < {1'b0, env_period_ff}) begin
                  env_counter_in = cnt_p1[15:0];
               end else begin
                  env_counter_in = 16'd0;
                  unique case (k)
                     ptfm_pkg::SEG_UP: begin
                        if (env_level_ff >= 5'd31) begin
                           env_seg_in   = nseg;
                           env_level_in = ptfm_pkg::restart_level(env_shape_ff, nseg);
                        end else begin
                           env_level_in = env_level_ff + 5'd1;
                        end
                     end
                     ptfm_pkg::SEG_DOWN: begin
                        if (env_level_ff == 5'd0) begin
                           env_seg_in   = nseg;
                           env_level_in = ptfm_pkg::restart_level(env_shape_ff, nseg);
                        end else begin
                           env_level_in = env_level_ff - 5'd1;
                        end
                     end
                     default: env_level_in = env_level_ff;
                  endcase
                  for (int c = 0; c < 3; c++) begin
                     mask_in[15 + c] = shadow_ff[8 + c][4];
                  end
               end
            end
            ptfm_pkg::ACT_PAN: begin
               mask_in[20:18] = 3'b111;
               mask_in[23:21] = 3'b111;
            end
            default: mask_in = mask_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) shadow_ff[i] <= 8'd0;
         env_counter_ff <= 16'd0;
         env_period_ff  <= 16'd1;
         env_shape_ff   <= 4'd0;
         env_seg_ff     <= 1'b0;
         env_level_ff   <= 5'd0;
         mask_ff        <= '0;
      end else begin
         shadow_ff      <= shadow_in;
         env_counter_ff <= env_counter_in;
         env_period_ff  <= env_period_in;
         env_shape_ff   <= env_shape_in;
         env_seg_ff     <= env_seg_in;
         env_level_ff   <= env_level_in;
         mask_ff        <= mask_in;
      end
   end

endmodule

// ===== rtl/ptfm_fifo.sv =====
// small op queue between the front sequencer and the key/output stage
module ptfm_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptfm_pkg::op_type push_op,
   input  logic             pop,
   output ptfm_pkg::op_type head_op,
   output logic             empty,
   output logic             full
);

   ptfm_pkg::op_type                entry_ff [ptfm_pkg::FIFO_DEPTH];
   logic [ptfm_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ptfm_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ptfm_pkg::FIFO_CNT_W-1:0] count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == ptfm_pkg::FIFO_CNT_W'(ptfm_pkg::FIFO_DEPTH));
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ptfm_pkg::FIFO_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + ptfm_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + ptfm_pkg::FIFO_CNT_W'(push) - ptfm_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/ptfm_back.sv =====
// back stage: iterative log2 key calculation and the response output register
module ptfm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ptfm_pkg::op_type            head_op,
   input  logic                        q_empty,
   output logic                        q_pop,
   input  logic [ptfm_pkg::KEY_W-1:0]  key_offset,
   ptfm_rsp_if.source                  rsp_bus
);

   ptfm_pkg::back_state_type state_ff, state_in;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_addr_ff, out_addr_in;
   logic [7:0]                 out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;
   logic [ptfm_pkg::N_W-1:0]   n_ff, n_in;
   logic [1:0]                 ch_ff, ch_in;
   logic                       last_ff, last_in;
   logic [3:0]                 exp_ff, exp_in;
   logic [30:0]                mant_ff, mant_in;
   logic [15:0]                frac_ff, frac_in;
   logic [3:0]                 cnt_ff, cnt_in;
   logic [ptfm_pkg::KEY_W-1:0] key_ff, key_in;

   logic        out_free;
   logic [3:0]  head_exp;
   logic [61:0] square;
   logic [31:0] sq_top;
   logic [19:0] log_q16;
   logic [23:0] twelve_log;
   logic [7:0]  ip;
   logic [15:0] oct_prod;
   logic [4:0]  oct_raw;
   logic [2:0]  oct;
   logic [7:0]  note_full;
   logic [7:0]  kc;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.fm_addr = out_addr_ff;
   assign rsp_bus.fm_data = out_data_ff;
   assign rsp_bus.last    = out_last_ff;

   always_comb begin
      head_exp = 4'd0;
      for (int i = 0; i < ptfm_pkg::N_W; i++) begin
         if (head_op.value[i]) head_exp = 4'(i);
      end
   end

   assign square     = 62'(mant_ff) * 62'(mant_ff);
   assign sq_top     = square[61:30];
   assign log_q16    = {exp_ff, frac_ff};
   assign twelve_log = {1'b0, log_q16, 3'd0} + {2'd0, log_q16, 2'd0};

   // octave and note from the integer key, divide by 12 via reciprocal
   assign ip        = key_ff[23:16];
   assign oct_prod  = 16'(ip) * 16'd171;
   assign oct_raw   = oct_prod[15:11];
   assign oct       = (oct_raw > 5'd7) ? 3'd7 : oct_raw[2:0];
   assign note_full = ip - 8'(oct_raw) * 8'd12;
   assign kc        = {1'b0, oct, ptfm_pkg::note_code(note_full[3:0])};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptfm_pkg::B_IDLE: begin
            if (!q_empty && head_op.is_key) begin
               state_in = (head_op.value == '0) ? ptfm_pkg::B_KEY : ptfm_pkg::B_LOG;
            end
         end
         ptfm_pkg::B_LOG: begin
            if (cnt_ff == 4'(ptfm_pkg::LOG_STEPS - 1)) state_in = ptfm_pkg::B_KEY;
         end
         ptfm_pkg::B_KEY: state_in = ptfm_pkg::B_KC;
         ptfm_pkg::B_KC:  if (out_free) state_in = ptfm_pkg::B_KF;
         ptfm_pkg::B_KF:  if (out_free) state_in = ptfm_pkg::B_IDLE;
         default:         state_in = ptfm_pkg::B_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_addr_in  = out_addr_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      n_in         = n_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      exp_in       = exp_ff;
      mant_in      = mant_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      unique case (state_ff)
         ptfm_pkg::B_IDLE: begin
            if (!q_empty && head_op.is_key) begin
               q_pop   = 1'b1;
               n_in    = head_op.value;
               ch_in   = head_op.addr[1:0];
               last_in = head_op.last;
               exp_in  = head_exp;
               mant_in = 31'({17'd0, head_op.value} << (5'd30 - 5'(head_exp)));
               frac_in = 16'd0;
               cnt_in  = 4'd0;
            end else if (!q_empty && out_free) begin
               q_pop        = 1'b1;
               out_valid_in = 1'b1;
               out_addr_in  = head_op.addr;
               out_data_in  = head_op.value[7:0];
               out_last_in  = head_op.last;
            end
         end
         ptfm_pkg::B_LOG: begin
            cnt_in = cnt_ff + 4'd1;
            if (sq_top[31]) begin
               mant_in = sq_top[31:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               mant_in = sq_top[30:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
         end
         ptfm_pkg::B_KEY: begin
            if (n_ff == '0 || twelve_log >= key_offset) key_in = '0;
            else key_in = key_offset - twelve_log;
         end
         ptfm_pkg::B_KC: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_addr_in  = ptfm_pkg::FM_KC_BASE + 8'(ch_ff);
               out_data_in  = kc;
               out_last_in  = 1'b0;
            end
         end
         ptfm_pkg::B_KF: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_addr_in  = ptfm_pkg::FM_KF_BASE + 8'(ch_ff);
               out_data_in  = {key_ff[15:10], 2'b00};
               out_last_in  = last_ff;
            end
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      ch_ff       <= ch_in;
      last_ff     <= last_in;
      exp_ff      <= exp_in;
      mant_ff     <= mant_in;
      frac_ff     <= frac_in;
      key_ff      <= key_in;
      out_addr_ff <= out_addr_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptfm_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= 4'd0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // mantissa stays normalized in [1,2) while squaring
   a_mant_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptfm_pkg::B_LOG) |-> mant_ff[30])
      else $error("log2 mantissa lost normalization");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_out_from_state: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |->
         ($past(state_ff) == ptfm_pkg::B_IDLE || $past(state_ff) == ptfm_pkg::B_KC ||
          $past(state_ff) == ptfm_pkg::B_KF))
      else $error("response loaded outside an output state");

   a_key_last_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptfm_pkg::B_KC && out_free) |=>
         (state_ff == ptfm_pkg::B_KF && !out_last_ff))
      else $error("key code write not followed by fraction write");

endmodule

// ===== rtl/psg_to_fm_register_translator_top.sv =====
// psg to fm register translator top level with configuration registers
//
// Each request (psg register write, envelope tick or pan refresh) is taken
// when the front sequencer is idle, then expanded into up to 18 fm
// register writes, one op per cycle into a four-entry queue while it is not
// full. Plain writes leave the back stage at one per cycle while the response
// is ready; each key code/fraction pair waits on the 16 serial squaring steps
// of the log2 unit (one 31x31 multiply per step) for a nonzero value, then is
// sent as two writes from the key code and fraction states.
module psg_to_fm_register_translator_top (
   input  logic                        clock,
   input  logic                        reset,
   ptfm_req_if.sink                    req_bus,
   ptfm_rsp_if.source                  rsp_bus,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [ptfm_pkg::KEY_W-1:0]  csr_wdata
);

   logic [ptfm_pkg::KEY_W-1:0] key_offset_ff, key_offset_in;
   logic [1:0]                 stereo_mode_ff, stereo_mode_in;

   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   ptfm_pkg::op_type push_op;
   ptfm_pkg::op_type head_op;

   always_comb begin
      key_offset_in  = key_offset_ff;
      stereo_mode_in = stereo_mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            ptfm_pkg::CSR_KEY_OFFSET:  key_offset_in  = csr_wdata;
            ptfm_pkg::CSR_STEREO_MODE: stereo_mode_in = csr_wdata[1:0];
            default:                   key_offset_in  = key_offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_offset_ff  <= ptfm_pkg::KEY_OFFSET_RESET;
         stereo_mode_ff <= 2'd0;
      end else begin
         key_offset_ff  <= key_offset_in;
         stereo_mode_ff <= stereo_mode_in;
      end
   end

   ptfm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .stereo_mode (stereo_mode_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_op        (push_op)
   );

   ptfm_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .pop     (q_pop),
      .head_op (head_op),
      .empty   (q_empty),
      .full    (q_full)
   );

   ptfm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_op    (head_op),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .key_offset (key_offset_ff),
      .rsp_bus    (rsp_bus)
   );

endmodule
